### sv/semaphore_table_with_wait_queues_core_defines.svh
// ----------------------------------------------------------------------------
// Semaphore table assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_CORE_DEFINES_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_CORE_DEFINES_SVH

// Same-cycle implication.
`define STWQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STWQ_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/stwq_pkg.sv
// ----------------------------------------------------------------------------
// Semaphore table package
// Shared widths, codes and control bundles.
// ----------------------------------------------------------------------------
package stwq_pkg;

  localparam int unsigned NUM_SEMS_DEF   = 16;
  localparam int unsigned WAIT_DEPTH_DEF = 8;
  localparam int unsigned PID_BITS_DEF   = 8;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned ID_W        = 32;
  localparam int unsigned INIT_W      = 16;
  localparam int unsigned PID_FIELD_W = 8;
  localparam int unsigned ATTACH_W    = 16;

  localparam logic [ATTACH_W-1:0] ATTACH_MAX = '1;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_WAIT  = 2'd2,
    OP_POST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNKNOWN    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_WAIT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_WREAD  = 2'd2,
    S_COMMIT = 2'd3
  } state_e;

  typedef struct packed {
    logic done;
    logic hit;
    logic free_found;
  } scan_flags_t;

  typedef struct packed {
    logic    ent_we;
    logic    use_free;
    logic    vld_set;
    logic    vld_clr;
    logic    wq_we;
    status_e status;
    logic    blocked;
    logic    wake_valid;
    logic    ret_en;
  } upd_ctrl_t;

endpackage

### sv/stwq_if.sv
// ----------------------------------------------------------------------------
// Semaphore table channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface stwq_req_if import stwq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [ID_W-1:0]        sem_id;
  logic [INIT_W-1:0]      initial_value;
  logic [PID_FIELD_W-1:0] caller_pid;

  modport source (output valid, op, sem_id, initial_value, caller_pid, input ready);
  modport sink   (input valid, op, sem_id, initial_value, caller_pid, output ready);
endinterface

interface stwq_rsp_if import stwq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [ID_W-1:0]        returned_id;
  logic                   caller_blocked;
  logic                   wake_valid;
  logic [PID_FIELD_W-1:0] wake_pid;

  modport source (output valid, status, returned_id, caller_blocked, wake_valid, wake_pid,
                  input ready);
  modport sink   (input valid, status, returned_id, caller_blocked, wake_valid, wake_pid,
                  output ready);
endinterface

### sv/stwq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/stwq_scan.sv
// ----------------------------------------------------------------------------
// Semaphore id scan unit
// Walks the entry RAM one entry per cycle through one shared id compare.
// ----------------------------------------------------------------------------
module stwq_scan import stwq_pkg::*; #(
  parameter int unsigned NUM_SEMS = NUM_SEMS_DEF,
  parameter int unsigned IDX_W    = $clog2(NUM_SEMS_DEF)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ID_W-1:0]     key_i,
  input  logic [NUM_SEMS-1:0] valid_i,
  input  logic [ID_W-1:0]     rd_id_i,
  output logic                re_o,
  output logic [IDX_W-1:0]    raddr_o,
  output scan_flags_t         flags_o,
  output logic [IDX_W-1:0]    hit_idx_o,
  output logic [IDX_W-1:0]    free_idx_o
);

  localparam int unsigned CNT_W = IDX_W + 1;

  logic             active_q;
  logic [CNT_W-1:0] iss_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;

  logic issue_more, cur_valid, hit, last, done, free_now;

  assign issue_more = active_q && (iss_q != CNT_W'(NUM_SEMS));
  assign re_o       = issue_more;
  assign raddr_o    = iss_q[IDX_W-1:0];

  assign cur_valid = valid_i[cmp_idx_q];
  assign hit       = cmp_vld_q && cur_valid && (rd_id_i == key_i);
  assign last      = cmp_vld_q && (cmp_idx_q == IDX_W'(NUM_SEMS - 1));
  assign done      = active_q && (hit || last);
  assign free_now  = cmp_vld_q && !cur_valid && !free_found_q;

  assign flags_o.done       = done;
  assign flags_o.hit        = hit;
  assign flags_o.free_found = free_found_q || free_now;
  assign hit_idx_o          = cmp_idx_q;
  assign free_idx_o         = free_found_q ? free_idx_q : cmp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      iss_q        <= '0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else if (start_i) begin
      active_q     <= 1'b1;
      iss_q        <= '0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else if (active_q) begin
      if (done) begin
        active_q  <= 1'b0;
        cmp_vld_q <= 1'b0;
      end else begin
        cmp_vld_q <= issue_more;
        if (issue_more) begin
          iss_q <= iss_q + CNT_W'(1);
        end
        if (free_now) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  // Index and free-slot payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (active_q && !done) begin
      cmp_idx_q <= iss_q[IDX_W-1:0];
      if (free_now) begin
        free_idx_q <= cmp_idx_q;
      end
    end
  end

endmodule

### sv/stwq_upd.sv
// ----------------------------------------------------------------------------
// Semaphore entry update unit
// Applies one operation to a fetched entry and its wait queue pointers.
// ----------------------------------------------------------------------------
module stwq_upd import stwq_pkg::*; #(
  parameter int unsigned WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned PID_BITS   = PID_BITS_DEF,
  parameter int unsigned HEAD_W     = 3,
  parameter int unsigned FILL_W     = 4
) (
  input  op_e                   op_i,
  input  logic                  hit_i,
  input  logic                  free_found_i,
  input  logic [COUNT_BITS-1:0] init_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [ATTACH_W-1:0]   attach_i,
  input  logic [HEAD_W-1:0]     head_i,
  input  logic [FILL_W-1:0]     fill_i,
  input  logic [PID_BITS-1:0]   wq_rdata_i,
  output upd_ctrl_t             ctrl_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic [ATTACH_W-1:0]   attach_o,
  output logic [HEAD_W-1:0]     head_o,
  output logic [FILL_W-1:0]     fill_o,
  output logic [HEAD_W-1:0]     slot_o,
  output logic [PID_BITS-1:0]   wake_pid_o
);

  localparam int unsigned SUM_W = FILL_W + 1;

  logic [SUM_W-1:0]    enq_sum, enq_wrap, head_inc;
  logic [HEAD_W-1:0]   enq_slot, next_head;
  logic [ATTACH_W-1:0] att_dec;

  // Ring pointer arithmetic: both sums stay below twice the depth.
  assign enq_sum   = SUM_W'(head_i) + SUM_W'(fill_i);
  assign enq_wrap  = enq_sum - SUM_W'(WAIT_DEPTH);
  assign enq_slot  = (enq_sum >= SUM_W'(WAIT_DEPTH)) ? enq_wrap[HEAD_W-1:0]
                                                      : enq_sum[HEAD_W-1:0];
  assign head_inc  = SUM_W'(head_i) + SUM_W'(1);
  assign next_head = (head_inc >= SUM_W'(WAIT_DEPTH)) ? '0 : head_inc[HEAD_W-1:0];
  assign att_dec   = (attach_i == '0) ? '0 : attach_i - ATTACH_W'(1);

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.status = ST_OK;
    count_o       = count_i;
    attach_o      = attach_i;
    head_o        = head_i;
    fill_o        = fill_i;
    slot_o        = head_i;
    wake_pid_o    = '0;
    case (op_i)
      OP_OPEN: begin
        if (hit_i) begin
          ctrl_o.ent_we = 1'b1;
          ctrl_o.ret_en = 1'b1;
          if (attach_i != ATTACH_MAX) begin
            attach_o = attach_i + ATTACH_W'(1);
          end
        end else if (free_found_i) begin
          ctrl_o.ent_we   = 1'b1;
          ctrl_o.use_free = 1'b1;
          ctrl_o.vld_set  = 1'b1;
          ctrl_o.ret_en   = 1'b1;
          count_o         = init_i;
          attach_o        = ATTACH_W'(1);
          head_o          = '0;
          fill_o          = '0;
        end else begin
          ctrl_o.status = ST_TABLE_FULL;
        end
      end
      OP_CLOSE: begin
        if (!hit_i) begin
          ctrl_o.status = ST_UNKNOWN;
        end else if (att_dec == '0) begin
          ctrl_o.vld_clr = 1'b1;
        end else begin
          ctrl_o.ent_we = 1'b1;
          attach_o      = att_dec;
        end
      end
      OP_WAIT: begin
        if (!hit_i) begin
          ctrl_o.status = ST_UNKNOWN;
        end else if (count_i != '0) begin
          ctrl_o.ent_we = 1'b1;
          count_o       = count_i - COUNT_BITS'(1);
        end else if (fill_i >= FILL_W'(WAIT_DEPTH)) begin
          ctrl_o.status = ST_WAIT_FULL;
        end else begin
          ctrl_o.ent_we  = 1'b1;
          ctrl_o.wq_we   = 1'b1;
          ctrl_o.blocked = 1'b1;
          slot_o         = enq_slot;
          fill_o         = fill_i + FILL_W'(1);
        end
      end
      OP_POST: begin
        if (!hit_i) begin
          ctrl_o.status = ST_UNKNOWN;
        end else if (fill_i != '0) begin
          ctrl_o.ent_we     = 1'b1;
          ctrl_o.wake_valid = 1'b1;
          wake_pid_o        = wq_rdata_i;
          head_o            = next_head;
          fill_o            = fill_i - FILL_W'(1);
        end else if (count_i != {COUNT_BITS{1'b1}}) begin
          ctrl_o.ent_we = 1'b1;
          count_o       = count_i + COUNT_BITS'(1);
        end
      end
      default: begin
        ctrl_o.status = ST_UNKNOWN;
      end
    endcase
  end

endmodule

### sv/semaphore_table_with_wait_queues_core.sv
// ----------------------------------------------------------------------------
// Semaphore table with wait queues
// A request starts an id scan that ends at the matching entry, or at the last
// one on a miss; a post that dequeues a waiter then reads the waiter RAM. The
// commit loads the response register. A request is taken only in idle, once the
// last has committed; the id scan compares one entry RAM word per cycle. Reset clears
// all entry valid bits and the control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "semaphore_table_with_wait_queues_core_defines.svh"

module semaphore_table_with_wait_queues_core import stwq_pkg::*; #(
  parameter int unsigned NUM_SEMS   = NUM_SEMS_DEF,
  parameter int unsigned WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int unsigned PID_BITS   = PID_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stwq_req_if.sink     req_i,
  stwq_rsp_if.source   rsp_o
);

  // --------------------------------------------------------------------------
  // Derived sizes. Each entry RAM word packs, from the top down:
  // id, count, attach count, queue head, queue fill.
  // --------------------------------------------------------------------------
  localparam int unsigned IDX_W    = $clog2(NUM_SEMS);
  localparam int unsigned HEAD_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned FILL_W   = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned FILL_LO  = 0;
  localparam int unsigned HEAD_LO  = FILL_LO + FILL_W;
  localparam int unsigned ATT_LO   = HEAD_LO + HEAD_W;
  localparam int unsigned CNT_LO   = ATT_LO + ATTACH_W;
  localparam int unsigned ID_LO    = CNT_LO + COUNT_BITS;
  localparam int unsigned REC_W    = ID_LO + ID_W;
  localparam int unsigned WQ_DEPTH = NUM_SEMS * WAIT_DEPTH;
  localparam int unsigned WA_W     = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
  localparam int unsigned PW       = (PID_BITS > PID_FIELD_W) ? PID_BITS : PID_FIELD_W;
  localparam int unsigned CW       = (COUNT_BITS > INIT_W) ? COUNT_BITS : INIT_W;

  // --------------------------------------------------------------------------
  // Sequencer state and request registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [1:0]            op_q;
  logic [ID_W-1:0]       id_q;
  logic [COUNT_BITS-1:0] init_q;
  logic [PID_BITS-1:0]   pid_q;
  logic                  hit_q;
  logic                  free_found_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic [ID_LO-1:0]      rec_q;
  logic [NUM_SEMS-1:0]   valid_q;

  // Response register: parts the sequencer from the response channel.
  logic                   out_valid_q;
  logic [1:0]             status_q;
  logic [ID_W-1:0]        ret_id_q;
  logic                   blocked_q;
  logic                   wake_valid_q;
  logic [PID_FIELD_W-1:0] wake_pid_q;

  logic accept, commit_go, scan_start, wq_re;

  logic [CW-1:0] init_ext;
  logic [PW-1:0] pid_ext, wake_ext;

  // Entry RAM ports
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  logic [REC_W-1:0] ent_wdata, ent_rdata;
  logic             ent_re;

  // Waiter RAM ports
  logic [WA_W-1:0]     wq_addr;
  logic [PID_BITS-1:0] wq_rdata;
  logic                wq_we;

  // Scan unit results
  scan_flags_t      scan_flags;
  logic [IDX_W-1:0] scan_hit_idx, scan_free_idx;

  // Update unit results
  upd_ctrl_t             ctrl;
  logic [COUNT_BITS-1:0] count_n;
  logic [ATTACH_W-1:0]   attach_n;
  logic [HEAD_W-1:0]     head_n;
  logic [FILL_W-1:0]     fill_n;
  logic [HEAD_W-1:0]     slot;
  logic [PID_BITS-1:0]   wake_pid_n;

  assign accept = req_i.valid && req_i.ready;

  // Narrow or widen the request fields to the configured widths.
  assign init_ext = CW'(req_i.initial_value);
  assign pid_ext  = PW'(req_i.caller_pid);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_flags.done) begin
          // Post with queued waiters fetches the head pid first.
          if (scan_flags.hit && (op_e'(op_q) == OP_POST) &&
              (ent_rdata[FILL_LO +: FILL_W] != '0)) begin
            state_d = S_WREAD;
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_WREAD: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    req_i.ready = 1'b0;
    scan_start  = 1'b0;
    wq_re       = 1'b0;
    commit_go   = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        scan_start  = req_i.valid;
      end
      S_SCAN: begin
      end
      S_WREAD: begin
        wq_re = 1'b1;
      end
      S_COMMIT: begin
        // Commit only when the response register is free or draining.
        commit_go = !out_valid_q || rsp_o.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Request capture and scan result latch
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.op;
      id_q   <= req_i.sem_id;
      init_q <= init_ext[COUNT_BITS-1:0];
      pid_q  <= pid_ext[PID_BITS-1:0];
    end
    if ((state_q == S_SCAN) && scan_flags.done) begin
      hit_q        <= scan_flags.hit;
      free_found_q <= scan_flags.free_found;
      hit_idx_q    <= scan_hit_idx;
      free_idx_q   <= scan_free_idx;
      rec_q        <= ent_rdata[ID_LO-1:0];
    end
  end

  // Valid bits: set on create, clear when the last attachment closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (commit_go) begin
      if (ctrl.vld_set) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (ctrl.vld_clr) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Id scan over the entry RAM
  // --------------------------------------------------------------------------
  stwq_scan #(
    .NUM_SEMS (NUM_SEMS),
    .IDX_W    (IDX_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .key_i      (id_q),
    .valid_i    (valid_q),
    .rd_id_i    (ent_rdata[ID_LO +: ID_W]),
    .re_o       (ent_re),
    .raddr_o    (ent_raddr),
    .flags_o    (scan_flags),
    .hit_idx_o  (scan_hit_idx),
    .free_idx_o (scan_free_idx)
  );

  // --------------------------------------------------------------------------
  // Entry update
  // --------------------------------------------------------------------------
  stwq_upd #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .PID_BITS   (PID_BITS),
    .HEAD_W     (HEAD_W),
    .FILL_W     (FILL_W)
  ) u_upd (
    .op_i         (op_e'(op_q)),
    .hit_i        (hit_q),
    .free_found_i (free_found_q),
    .init_i       (init_q),
    .count_i      (rec_q[CNT_LO +: COUNT_BITS]),
    .attach_i     (rec_q[ATT_LO +: ATTACH_W]),
    .head_i       (rec_q[HEAD_LO +: HEAD_W]),
    .fill_i       (rec_q[FILL_LO +: FILL_W]),
    .wq_rdata_i   (wq_rdata),
    .ctrl_o       (ctrl),
    .count_o      (count_n),
    .attach_o     (attach_n),
    .head_o       (head_n),
    .fill_o       (fill_n),
    .slot_o       (slot),
    .wake_pid_o   (wake_pid_n)
  );

  // --------------------------------------------------------------------------
  // Entry RAM: scan reads, commit writes back the updated word
  // --------------------------------------------------------------------------
  assign ent_we    = commit_go && ctrl.ent_we;
  assign ent_waddr = ctrl.use_free ? free_idx_q : hit_idx_q;
  assign ent_wdata = {id_q, count_n, attach_n, head_n, fill_n};

  stwq_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SEMS)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // --------------------------------------------------------------------------
  // Waiter RAM: each entry owns WAIT_DEPTH consecutive slots
  // --------------------------------------------------------------------------
  assign wq_addr = WA_W'(hit_idx_q) * WA_W'(WAIT_DEPTH) + WA_W'(slot);
  assign wq_we   = commit_go && ctrl.wq_we;

  stwq_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (WQ_DEPTH)
  ) u_wq_ram (
    .clk_i   (clk_i),
    .we_i    (wq_we),
    .waddr_i (wq_addr),
    .wdata_i (pid_q),
    .re_i    (wq_re),
    .raddr_i (wq_addr),
    .rdata_o (wq_rdata)
  );

  // --------------------------------------------------------------------------
  // Response register: load on commit, drop on the response beat
  // --------------------------------------------------------------------------
  assign wake_ext = PW'(wake_pid_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_go) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      status_q     <= ctrl.status;
      ret_id_q     <= ctrl.ret_en ? id_q : '0;
      blocked_q    <= ctrl.blocked;
      wake_valid_q <= ctrl.wake_valid;
      wake_pid_q   <= wake_ext[PID_FIELD_W-1:0];
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.returned_id    = ret_id_q;
  assign rsp_o.caller_blocked = blocked_q;
  assign rsp_o.wake_valid     = wake_valid_q;
  assign rsp_o.wake_pid       = wake_pid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `STWQ_ASSERT_NXT(a_accept_scans, accept, state_q == S_SCAN, "request beat did not scan")
  `STWQ_ASSERT_IMP(a_no_write_in_scan, state_q == S_SCAN, !ent_we, "entry write during scan")
  `STWQ_ASSERT_NXT(a_commit_loads, commit_go, rsp_o.valid, "commit did not load response")
  `STWQ_ASSERT_IMP(a_block_wake_excl, rsp_o.valid,
                   !(rsp_o.caller_blocked && rsp_o.wake_valid), "blocked and wake together")
  `STWQ_ASSERT_IMP(a_blocked_ok, rsp_o.valid && rsp_o.caller_blocked,
                   rsp_o.status == ST_OK, "blocked with error status")

endmodule
